[hw/rtl/grc_pkg.sv]
`default_nettype none
package grc_pkg;

    localparam int MAP_DIM   = 32;
    localparam int MAX_STEPS = 64;

    localparam int MAP_CELLS = MAP_DIM * MAP_DIM;
    localparam int ADDR_W    = $clog2(MAP_CELLS);
    localparam int PMAP_W    = 5;
    localparam int MAPC_W    = $clog2(MAP_DIM);
    localparam int COORD_W   = ((MAPC_W > PMAP_W) ? MAPC_W : PMAP_W) + $clog2(MAX_STEPS) + 2;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);

    localparam int CAM_W   = 29;
    localparam int RAY_W   = 32;
    localparam int DELTA_W = 31;
    localparam int SD_W    = 33 + $clog2(MAX_STEPS);
    localparam int DIV_W   = (SD_W > 34) ? SD_W : 34;
    localparam int CNT_W   = $clog2(DIV_W + 1);

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_X     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 4'd7;

    localparam logic [DELTA_W-1:0] DELTA_MAX  = 31'h7FFF_FFFF;
    localparam logic [23:0]        RED_WALL   = 24'hAA0000;
    localparam logic [23:0]        GREEN_WALL = 24'h00AA00;
    localparam logic [23:0]        HALF_MASK  = 24'h7F7F7F;
    localparam int                 FRAC_BITS  = 16;

    localparam logic [CNT_W-1:0] CAM_BITS   = CNT_W'(28);
    localparam logic [CNT_W-1:0] DELTA_BITS = CNT_W'(33);
    localparam logic [CNT_W-1:0] LINE_BITS  = CNT_W'(27);

    typedef enum logic [1:0] {
        DIV_CAM,
        DIV_DX,
        DIV_DY,
        DIV_LINE
    } div_sel_t;

    typedef struct packed {
        logic     cast_load;
        logic     cell_write;
        logic     div_start;
        div_sel_t div_sel;
        logic     cam_take;
        logic     rayx_calc;
        logic     rayy_calc;
        logic     dx_take;
        logic     dy_take;
        logic     sidex_init;
        logic     sidey_init;
        logic     walk_step;
        logic     map_exit;
        logic     cell_take;
        logic     dist_calc;
        logic     line_take;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_of_map;
        logic cell_hit;
        logic steps_max;
    } dp_status_t;

endpackage
`default_nettype wire

[hw/rtl/grid_raycast_column_top.sv]
// Grid raycaster, one screen column per cast. An item is taken when start is
// high and busy is low: req_type 0 writes one map cell in that same cycle and
// the block stays free; req_type 1 casts a column and holds busy until done.
// A cast walks at most MAX_STEPS DDA steps: four divisions run one quotient
// bit per cycle on a single shared divider (28, 33, 33 and 27 bits), and each
// DDA step is stepping, reading the map RAM and testing the cell in turn. The
// result is shown for exactly one cycle with done high and cannot be held off,
// so take it then. Configuration is written through cfg_valid/cfg_index/
// cfg_data (always ready); the user must write it only while no cast is in
// flight, as the block does not enforce this. The map RAM has no reset.
`default_nettype none
module grid_raycast_column_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           req_type,
    input  wire logic [9:0]                     cell_index,
    input  wire logic [7:0]                     cell_value,
    input  wire logic [9:0]                     column,
    output logic                                done,
    output logic [9:0]                          draw_start,
    output logic [9:0]                          draw_end,
    output logic [23:0]                         wall_color,
    output logic                                hit_side,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [grc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [grc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import grc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    grc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    grc_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cell_index (cell_index),
        .cell_value (cell_value),
        .column     (column),
        .draw_start (draw_start),
        .draw_end   (draw_end),
        .wall_color (wall_color),
        .hit_side   (hit_side)
    );
endmodule
`default_nettype wire

[hw/rtl/grc_div.sv]
`default_nettype none
module grc_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [grc_pkg::DIV_W-1:0] num,
    input  wire logic [grc_pkg::DIV_W-1:0] den,
    input  wire logic [grc_pkg::CNT_W-1:0] bits,
    output logic                           done,
    output logic [grc_pkg::DIV_W-1:0]      quo
);
    import grc_pkg::*;

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] num_reg;
    logic [DIV_W-1:0] den_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg, num_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= bits;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num << (CNT_W'(DIV_W) - bits);
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[DIV_W-2:0], 1'b0};
            rem_reg <= ge ? DIV_W'(trial - {1'b0, den_reg}) : trial[DIV_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule
`default_nettype wire

[hw/rtl/grc_ctrl.sv]
`default_nettype none
module grc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                req_type,
    input  wire grc_pkg::dp_status_t status,
    output grc_pkg::ctrl_cmd_t       cmd,
    output logic                     busy,
    output logic                     done
);
    import grc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CAM_GO,
        S_CAM_WAIT,
        S_RAYX,
        S_RAYY,
        S_DX_GO,
        S_DX_WAIT,
        S_DY_GO,
        S_DY_WAIT,
        S_SIDEX,
        S_SIDEY,
        S_STEP,
        S_PROBE,
        S_EVAL,
        S_DIST,
        S_LINE_GO,
        S_LINE_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        cmd        = '0;
        cmd.div_sel = DIV_CAM;
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type)
                    begin
                        cmd.cast_load = 1'b1;
                        state_next    = S_CAM_GO;
                    end
                    else
                    begin
                        cmd.cell_write = 1'b1;
                    end
                end
            end
            S_CAM_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_CAM;
                state_next    = S_CAM_WAIT;
            end
            S_CAM_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.cam_take = 1'b1;
                    state_next   = S_RAYX;
                end
            end
            S_RAYX:
            begin
                cmd.rayx_calc = 1'b1;
                state_next    = S_RAYY;
            end
            S_RAYY:
            begin
                cmd.rayy_calc = 1'b1;
                state_next    = S_DX_GO;
            end
            S_DX_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_DX;
                state_next    = S_DX_WAIT;
            end
            S_DX_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.dx_take = 1'b1;
                    state_next  = S_DY_GO;
                end
            end
            S_DY_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_DY;
                state_next    = S_DY_WAIT;
            end
            S_DY_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.dy_take = 1'b1;
                    state_next  = S_SIDEX;
                end
            end
            S_SIDEX:
            begin
                cmd.sidex_init = 1'b1;
                state_next     = S_SIDEY;
            end
            S_SIDEY:
            begin
                cmd.sidey_init = 1'b1;
                state_next     = S_STEP;
            end
            S_STEP:
            begin
                cmd.walk_step = 1'b1;
                state_next    = S_PROBE;
            end
            S_PROBE:
            begin
                if (status.out_of_map)
                begin
                    cmd.map_exit = 1'b1;
                    state_next   = S_DIST;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.cell_take = 1'b1;
                if (status.cell_hit || status.steps_max)
                    state_next = S_DIST;
                else
                    state_next = S_STEP;
            end
            S_DIST:
            begin
                cmd.dist_calc = 1'b1;
                state_next    = S_LINE_GO;
            end
            S_LINE_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_LINE;
                state_next    = S_LINE_WAIT;
            end
            S_LINE_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.line_take = 1'b1;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
endmodule
`default_nettype wire

[hw/rtl/grc_dpath.sv]
`default_nettype none
module grc_dpath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire grc_pkg::ctrl_cmd_t             cmd,
    output grc_pkg::dp_status_t                 status,
    input  wire logic                           cfg_we,
    input  wire logic [grc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [grc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [9:0]                     cell_index,
    input  wire logic [7:0]                     cell_value,
    input  wire logic [9:0]                     column,
    output logic [9:0]                          draw_start,
    output logic [9:0]                          draw_end,
    output logic [23:0]                         wall_color,
    output logic                                hit_side
);
    import grc_pkg::*;

    logic [20:0]        player_x_reg;
    logic [20:0]        player_y_reg;
    logic signed [17:0] dir_x_reg;
    logic signed [17:0] dir_y_reg;
    logic signed [17:0] plane_x_reg;
    logic signed [17:0] plane_y_reg;
    logic [10:0]        view_width_reg;
    logic [10:0]        view_height_reg;

    logic [7:0] wall_map [MAP_CELLS];
    logic [7:0] rd_reg;

    logic [9:0]                column_reg;
    logic signed [CAM_W-1:0]   cam_reg;
    logic signed [RAY_W-1:0]   rayx_reg;
    logic signed [RAY_W-1:0]   rayy_reg;
    logic [DELTA_W-1:0]        dx_reg;
    logic [DELTA_W-1:0]        dy_reg;
    logic [SD_W-1:0]           sx_reg;
    logic [SD_W-1:0]           sy_reg;
    logic signed [COORD_W-1:0] map_x_reg;
    logic signed [COORD_W-1:0] map_y_reg;
    logic [STEP_W-1:0]         step_cnt_reg;
    logic                      side_reg;
    logic                      green_reg;
    logic [DIV_W-1:0]          dist_reg;
    logic [9:0]                start_reg;
    logic [9:0]                end_reg;
    logic [23:0]               color_reg;
    logic                      hit_side_reg;

    logic [10:0] vw_eff;
    logic [10:0] vh_eff;
    logic [9:0]  vh_half;

    logic [DIV_W-1:0] div_num;
    logic [DIV_W-1:0] div_den;
    logic [CNT_W-1:0] div_bits;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;

    logic [RAY_W-1:0] absx;
    logic [RAY_W-1:0] absy;
    logic [DELTA_W-1:0] delta_q;

    logic signed [17:0]        mul_plane;
    logic signed [17:0]        mul_dir;
    logic signed [CAM_W+17:0]  ray_prod;
    logic signed [RAY_W-1:0]   ray_val;

    logic [16:0]         side_frac;
    logic [DELTA_W-1:0]  side_delta;
    logic [DELTA_W+16:0] side_prod;
    logic [SD_W-1:0]     side_val;

    logic [SD_W-1:0]    dist_val;
    logic [DIV_W-1:0]   half_line;
    logic [DIV_W:0]     end_sum;
    logic [9:0]         start_val;
    logic [9:0]         end_val;
    logic [23:0]        base_color;

    logic [ADDR_W-1:0] rd_addr;

    assign vw_eff  = (view_width_reg == '0) ? 11'd1 : view_width_reg;
    assign vh_eff  = (view_height_reg == '0) ? 11'd1 : view_height_reg;
    assign vh_half = vh_eff[10:1];

    assign absx = rayx_reg[RAY_W-1] ? RAY_W'(-rayx_reg) : RAY_W'(rayx_reg);
    assign absy = rayy_reg[RAY_W-1] ? RAY_W'(-rayy_reg) : RAY_W'(rayy_reg);

    always_comb
    begin
        div_num  = '0;
        div_den  = '0;
        div_bits = CAM_BITS;
        case (cmd.div_sel)
            DIV_CAM:
            begin
                div_num  = DIV_W'(column_reg) << 17;
                div_den  = DIV_W'(vw_eff);
                div_bits = CAM_BITS;
            end
            DIV_DX:
            begin
                div_num  = DIV_W'(1) << 32;
                div_den  = DIV_W'(absx);
                div_bits = DELTA_BITS;
            end
            DIV_DY:
            begin
                div_num  = DIV_W'(1) << 32;
                div_den  = DIV_W'(absy);
                div_bits = DELTA_BITS;
            end
            default:
            begin
                div_num  = DIV_W'(vh_eff) << FRAC_BITS;
                div_den  = dist_reg;
                div_bits = LINE_BITS;
            end
        endcase
    end

    grc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .bits  (div_bits),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign delta_q = (div_quo > DIV_W'(DELTA_MAX)) ? DELTA_MAX : div_quo[DELTA_W-1:0];

    assign mul_plane = cmd.rayy_calc ? plane_y_reg : plane_x_reg;
    assign mul_dir   = cmd.rayy_calc ? dir_y_reg : dir_x_reg;
    assign ray_prod  = mul_plane * cam_reg;
    assign ray_val   = RAY_W'(mul_dir) + RAY_W'(ray_prod >>> FRAC_BITS);

    always_comb
    begin
        if (cmd.sidey_init)
        begin
            side_delta = dy_reg;
            side_frac  = rayy_reg[RAY_W-1] ? {1'b0, player_y_reg[15:0]}
                                           : 17'h10000 - {1'b0, player_y_reg[15:0]};
        end
        else
        begin
            side_delta = dx_reg;
            side_frac  = rayx_reg[RAY_W-1] ? {1'b0, player_x_reg[15:0]}
                                           : 17'h10000 - {1'b0, player_x_reg[15:0]};
        end
    end
    assign side_prod = side_frac * side_delta;
    assign side_val  = SD_W'(side_prod >> FRAC_BITS);

    assign dist_val = side_reg ? (sy_reg - SD_W'(dy_reg)) : (sx_reg - SD_W'(dx_reg));

    assign half_line = div_quo >> 1;
    assign end_sum   = {1'b0, half_line} + (DIV_W + 1)'(vh_half);
    always_comb
    begin
        if (half_line >= DIV_W'(vh_half))
            start_val = '0;
        else
            start_val = vh_half - half_line[9:0];
        if (end_sum >= (DIV_W + 1)'(vh_eff))
            end_val = (vh_eff - 11'd1 > 11'd1023) ? 10'd1023 : 10'(vh_eff - 11'd1);
        else
            end_val = (end_sum > (DIV_W + 1)'(1023)) ? 10'd1023 : end_sum[9:0];
    end

    assign base_color = green_reg ? GREEN_WALL : RED_WALL;

    assign rd_addr = ADDR_W'(map_x_reg) * ADDR_W'(MAP_DIM) + ADDR_W'(map_y_reg);

    assign status.div_done   = div_done;
    assign status.out_of_map = map_x_reg[COORD_W-1] || map_y_reg[COORD_W-1]
                               || (map_x_reg >= COORD_W'(MAP_DIM))
                               || (map_y_reg >= COORD_W'(MAP_DIM));
    assign status.cell_hit   = (rd_reg != 8'd0);
    assign status.steps_max  = (step_cnt_reg == STEP_W'(MAX_STEPS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            player_x_reg    <= 21'd196608;
            player_y_reg    <= 21'd196608;
            dir_x_reg       <= -18'sd65536;
            dir_y_reg       <= 18'sd0;
            plane_x_reg     <= 18'sd0;
            plane_y_reg     <= 18'sd43253;
            view_width_reg  <= 11'd640;
            view_height_reg <= 11'd455;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PLAYER_X:    player_x_reg    <= cfg_data;
                REG_PLAYER_Y:    player_y_reg    <= cfg_data;
                REG_DIR_X:       dir_x_reg       <= $signed(cfg_data[17:0]);
                REG_DIR_Y:       dir_y_reg       <= $signed(cfg_data[17:0]);
                REG_PLANE_X:     plane_x_reg     <= $signed(cfg_data[17:0]);
                REG_PLANE_Y:     plane_y_reg     <= $signed(cfg_data[17:0]);
                REG_VIEW_WIDTH:  view_width_reg  <= cfg_data[10:0];
                REG_VIEW_HEIGHT: view_height_reg <= cfg_data[10:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cell_write && (32'(cell_index) < 32'(MAP_CELLS)))
            wall_map[ADDR_W'(cell_index)] <= cell_value;
        rd_reg <= wall_map[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cast_load)
        begin
            column_reg   <= column;
            map_x_reg    <= COORD_W'(player_x_reg[20:16]);
            map_y_reg    <= COORD_W'(player_y_reg[20:16]);
            step_cnt_reg <= '0;
            side_reg     <= 1'b0;
            green_reg    <= 1'b0;
        end
        if (cmd.cam_take)
            cam_reg <= $signed(CAM_W'(div_quo)) - CAM_W'(65536);
        if (cmd.rayx_calc)
            rayx_reg <= ray_val;
        if (cmd.rayy_calc)
            rayy_reg <= ray_val;
        if (cmd.dx_take)
            dx_reg <= (rayx_reg == '0) ? DELTA_MAX : delta_q;
        if (cmd.dy_take)
            dy_reg <= (rayy_reg == '0) ? DELTA_MAX : delta_q;
        if (cmd.sidex_init)
            sx_reg <= side_val;
        if (cmd.sidey_init)
            sy_reg <= side_val;
        if (cmd.walk_step)
        begin
            step_cnt_reg <= step_cnt_reg + 1'b1;
            if (sx_reg < sy_reg)
            begin
                sx_reg    <= sx_reg + SD_W'(dx_reg);
                map_x_reg <= rayx_reg[RAY_W-1] ? map_x_reg - 1'b1 : map_x_reg + 1'b1;
                side_reg  <= 1'b0;
            end
            else
            begin
                sy_reg    <= sy_reg + SD_W'(dy_reg);
                map_y_reg <= rayy_reg[RAY_W-1] ? map_y_reg - 1'b1 : map_y_reg + 1'b1;
                side_reg  <= 1'b1;
            end
        end
        if (cmd.map_exit)
            green_reg <= 1'b0;
        if (cmd.cell_take)
            green_reg <= (rd_reg == 8'd2);
        if (cmd.dist_calc)
            dist_reg <= (dist_val == '0) ? DIV_W'(1) : DIV_W'(dist_val);
        if (cmd.line_take)
        begin
            start_reg    <= start_val;
            end_reg      <= end_val;
            color_reg    <= side_reg ? ((base_color >> 1) & HALF_MASK) : base_color;
            hit_side_reg <= side_reg;
        end
    end

    assign draw_start = start_reg;
    assign draw_end   = end_reg;
    assign wall_color = color_reg;
    assign hit_side   = hit_side_reg;
endmodule
`default_nettype wire

[hw/rtl/grc_checker.sv]
`default_nettype none
module grc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        req_type,
    input wire logic        done,
    input wire logic [9:0]  draw_start,
    input wire logic [9:0]  draw_end,
    input wire logic [23:0] wall_color,
    input wire logic        hit_side
);
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (draw_start <= draw_end))
        else $error("draw span inverted");

    a_color_side: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hit_side ? (wall_color == 24'h550000 || wall_color == 24'h005500)
                           : (wall_color == 24'hAA0000 || wall_color == 24'h00AA00)))
        else $error("wall color does not match side");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !req_type) |=> !done)
        else $error("result after a map write");

    a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type) |=> (busy && !done))
        else $error("cast transfer did not start work");

    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");
endmodule

bind grid_raycast_column_top grc_checker u_grc_checker (.*);
`default_nettype wire
